/* src/smpq_pkg.sv */
package smpq_pkg;

  // Action codes carried by an input word.
  localparam logic [1:0] ACT_ADD      = 2'd0;
  localparam logic [1:0] ACT_COMPLETE = 2'd1;
  localparam logic [1:0] ACT_PEEK     = 2'd2;

  // Width of the configuration register and its reset value.
  localparam int unsigned LIMIT_W     = 5;
  localparam logic [4:0]  LIMIT_RESET = 5'd16;

  // Field widths of the words.
  localparam int unsigned PRIO_W  = 32;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned COUNT_W = 5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the accepted input word, restart the scan
    logic scan_rd;  // read the slot at the scan index and advance it
    logic finish;   // commit the operation and load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // the scan index points at the last slot
    logic out_free;   // the result register can take a new word this cycle
  } ctrl_sts_t;

endpackage

/* src/slotted_max_priority_queue.sv */
// Slotted max priority queue.
// Input channel (in_valid / in_stall) carries one word per operation: an
// action (add, complete highest, peek highest), a signed priority and a tag.
// Result channel (out_valid / out_stall) returns one word per operation with
// the ok flag, the top entry (zero on add or failure), the entry count and
// the empty flag. cfg_wr_en / cfg_wr_data set the slot limit; write it only
// while the queue is idle.
// An add finds the lowest free slot below the limit combinationally, so its
// result goes from acceptance through the done state to the result register.
// Complete and peek scan every slot through the single read port of the
// slot memory, one slot per cycle, so their result is written after the scan
// and the compare of the last slot read.
// One operation is in flight at a time: in_stall is high from acceptance
// until the result is written to the output register. A result waiting in
// that register does not block the next acceptance; while the receiver
// stalls with a result still held, the next result waits in the controller.
// Reset (rst_n low, synchronous) empties the queue, clears the count and
// sets the slot limit to sixteen. Slot contents are not cleared.
module slotted_max_priority_queue #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [smpq_pkg::LIMIT_W-1:0]          cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_action,
  input  logic signed [smpq_pkg::PRIO_W-1:0]    in_entry_priority,
  input  logic [smpq_pkg::TAG_W-1:0]            in_entry_tag,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_ok,
  output logic [smpq_pkg::TAG_W-1:0]            out_top_tag,
  output logic signed [smpq_pkg::PRIO_W-1:0]    out_top_priority,
  output logic [smpq_pkg::COUNT_W-1:0]          out_entry_count,
  output logic                                  out_queue_empty
);

  smpq_pkg::ctrl_cmd_t cmd;
  smpq_pkg::ctrl_sts_t sts;

  // Operation sequencer.
  smpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Slot storage, scan and result register.
  smpq_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_action         (in_action),
    .in_entry_priority (in_entry_priority),
    .in_entry_tag      (in_entry_tag),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ok            (out_ok),
    .out_top_tag       (out_top_tag),
    .out_top_priority  (out_top_priority),
    .out_entry_count   (out_entry_count),
    .out_queue_empty   (out_queue_empty)
  );

endmodule

/* src/smpq_ctrl.sv */
module smpq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_action,
  output logic                  in_stall,
  input  smpq_pkg::ctrl_sts_t   sts,
  output smpq_pkg::ctrl_cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;
  logic       needs_scan;

  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign needs_scan = (in_action == smpq_pkg::ACT_COMPLETE) ||
                      (in_action == smpq_pkg::ACT_PEEK);

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.scan_rd = 1'b0;
    cmd.finish  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = needs_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_LAST;
        end
      end
      // The last slot read is compared in this cycle.
      ST_LAST: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* src/smpq_dp.sv */
module smpq_dp #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [smpq_pkg::LIMIT_W-1:0]          cfg_wr_data,
  input  logic [1:0]                            in_action,
  input  logic signed [smpq_pkg::PRIO_W-1:0]    in_entry_priority,
  input  logic [smpq_pkg::TAG_W-1:0]            in_entry_tag,
  input  smpq_pkg::ctrl_cmd_t                   cmd,
  output smpq_pkg::ctrl_sts_t                   sts,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_ok,
  output logic [smpq_pkg::TAG_W-1:0]            out_top_tag,
  output logic signed [smpq_pkg::PRIO_W-1:0]    out_top_priority,
  output logic [smpq_pkg::COUNT_W-1:0]          out_entry_count,
  output logic                                  out_queue_empty
);

  localparam int unsigned IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW     = $clog2(SLOTS + 1);
  localparam int unsigned LW     = (CW > smpq_pkg::LIMIT_W) ? CW : smpq_pkg::LIMIT_W;
  localparam int unsigned LIM_MAX = (1 << smpq_pkg::LIMIT_W) - 1;
  localparam int unsigned FREE_N = (SLOTS < LIM_MAX) ? SLOTS : LIM_MAX;

  // Configuration and bookkeeping.
  logic [smpq_pkg::LIMIT_W-1:0]       limit_r;
  logic [SLOTS-1:0]                   valid_r;
  logic [CW-1:0]                      count_r;

  // Captured input word.
  logic [1:0]                         act_r;
  logic signed [smpq_pkg::PRIO_W-1:0] prio_r;
  logic [smpq_pkg::TAG_W-1:0]         tag_r;

  // Slot storage.
  logic [smpq_pkg::PRIO_W-1:0]        mem_prio [SLOTS];
  logic [smpq_pkg::TAG_W-1:0]         mem_tag  [SLOTS];

  // Scan pipeline.
  logic [IW-1:0]                      scan_idx_r;
  logic                               rd_pend_r;
  logic                               rd_vld_r;
  logic [IW-1:0]                      rd_idx_r;
  logic signed [smpq_pkg::PRIO_W-1:0] rd_prio_r;
  logic [smpq_pkg::TAG_W-1:0]         rd_tag_r;

  // Best entry seen so far.
  logic                               best_found_r;
  logic [IW-1:0]                      best_idx_r;
  logic signed [smpq_pkg::PRIO_W-1:0] best_prio_r;
  logic [smpq_pkg::TAG_W-1:0]         best_tag_r;
  logic                               take_rd;

  // Result register.
  logic                               out_valid_r;
  logic                               ok_r;
  logic [smpq_pkg::TAG_W-1:0]         top_tag_r;
  logic signed [smpq_pkg::PRIO_W-1:0] top_prio_r;
  logic [CW-1:0]                      res_count_r;

  // Add path.
  logic [LW-1:0]                      lim_eff;
  logic                               free_found;
  logic [IW-1:0]                      free_idx;
  logic                               add_ok;
  logic                               is_add;
  logic                               is_complete;
  logic                               is_peek;
  logic [CW-1:0]                      count_nxt;
  logic [CW+smpq_pkg::COUNT_W-1:0]    count_ext;

  assign is_add      = (act_r == smpq_pkg::ACT_ADD);
  assign is_complete = (act_r == smpq_pkg::ACT_COMPLETE);
  assign is_peek     = (act_r == smpq_pkg::ACT_PEEK);

  // Effective limit is the register clamped to the slot count.
  always_comb begin
    lim_eff = (LW'(limit_r) < LW'(SLOTS)) ? LW'(limit_r) : LW'(SLOTS);
  end

  // Lowest free slot below the effective limit.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = FREE_N - 1; i >= 0; i--) begin
      if (!valid_r[i] && (LW'(i) < lim_eff)) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  assign add_ok = is_add && free_found && (LW'(count_r) < lim_eff);

  // Count after the operation.
  always_comb begin
    count_nxt = count_r;
    if (add_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (is_complete && best_found_r && (count_r != '0)) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // A valid slot replaces the best one only on a strictly higher priority.
  assign take_rd = rd_pend_r && rd_vld_r &&
                   (!best_found_r || (rd_prio_r > best_prio_r));

  // Control state: limit, valid bits, count, scan, result handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= smpq_pkg::LIMIT_RESET;
      valid_r      <= '0;
      count_r      <= '0;
      scan_idx_r   <= '0;
      rd_pend_r    <= 1'b0;
      rd_vld_r     <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      rd_pend_r <= cmd.scan_rd;
      if (cmd.scan_rd) begin
        rd_vld_r   <= valid_r[scan_idx_r];
        scan_idx_r <= scan_idx_r + IW'(1);
      end
      if (cmd.load) begin
        scan_idx_r   <= '0;
        best_found_r <= 1'b0;
      end else if (take_rd) begin
        best_found_r <= 1'b1;
      end
      if (cmd.finish) begin
        count_r <= count_nxt;
        if (add_ok) begin
          valid_r[free_idx] <= 1'b1;
        end else if (is_complete && best_found_r) begin
          valid_r[best_idx_r] <= 1'b0;
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Slot memory: written on a successful add, read one slot per scan cycle.
  always_ff @(posedge clk) begin
    if (cmd.finish && add_ok) begin
      mem_prio[free_idx] <= prio_r;
      mem_tag[free_idx]  <= tag_r;
    end
    if (cmd.scan_rd) begin
      rd_prio_r <= mem_prio[scan_idx_r];
      rd_tag_r  <= mem_tag[scan_idx_r];
      rd_idx_r  <= scan_idx_r;
    end
  end

  // Payload registers: captured word, best entry and result word.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      prio_r <= in_entry_priority;
      tag_r  <= in_entry_tag;
    end
    if (take_rd) begin
      best_idx_r  <= rd_idx_r;
      best_prio_r <= rd_prio_r;
      best_tag_r  <= rd_tag_r;
    end
    if (cmd.finish) begin
      res_count_r <= count_nxt;
      top_tag_r   <= '0;
      top_prio_r  <= '0;
      if (is_add) begin
        ok_r <= add_ok;
      end else if (is_complete || is_peek) begin
        ok_r <= best_found_r;
        if (best_found_r) begin
          top_tag_r  <= best_tag_r;
          top_prio_r <= best_prio_r;
        end
      end else begin
        ok_r <= 1'b0;
      end
    end
  end

  assign sts.scan_last = (scan_idx_r == IW'(SLOTS - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign count_ext        = {{smpq_pkg::COUNT_W{1'b0}}, res_count_r};
  assign out_valid        = out_valid_r;
  assign out_ok           = ok_r;
  assign out_top_tag      = top_tag_r;
  assign out_top_priority = top_prio_r;
  assign out_entry_count  = count_ext[smpq_pkg::COUNT_W-1:0];
  assign out_queue_empty  = (res_count_r == '0);

endmodule
